@@ rtl/core/vpa_pkg.sv @@
`default_nettype none
package vpa_pkg;

  localparam int unsigned MaxBlocksDefault = 16;
  localparam int unsigned AddrBitsDefault  = 16;
  localparam int unsigned IdBits           = 16;
  localparam int unsigned ResetMemSize     = 1024;
  localparam int unsigned IdLimit          = 65535;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StBadSize = 3'd1;
  localparam logic [2:0] StNoSeg   = 3'd2;
  localparam logic [2:0] StIdUnk   = 3'd3;
  localparam logic [2:0] StFull    = 3'd4;

  localparam logic [1:0] FitBest  = 2'd0;
  localparam logic [1:0] FitWorst = 2'd1;
  localparam logic [1:0] FitFirst = 2'd2;

  localparam logic [0:0] ReqAlloc = 1'b0;
  localparam logic [0:0] ReqFree  = 1'b1;

  localparam logic [0:0] RegMemSize = 1'b0;
  localparam logic [0:0] RegFit     = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch request, clear scan pointers
    logic blk_step;   // examine one block entry
    logic seg_step;   // examine one segment entry
    logic apply;      // commit table entry edit at pointer
    logic shift;      // one shift step of the segment table
    logic finish;     // write result
  } vpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic blk_done;
    logic seg_done;
    logic shift_done;
    logic need_shift;
  } vpa_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/vpa_ctrl.sv @@
`default_nettype none
module vpa_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  output vpa_pkg::vpa_cmd_t     cmd_o,
  input  wire vpa_pkg::vpa_sts_t sts_i
);
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SBlk   = 3'd1;
  localparam logic [2:0] SSeg   = 3'd2;
  localparam logic [2:0] SApply = 3'd3;
  localparam logic [2:0] SShift = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = SBlk;
        end
      end
      SBlk: begin
        cmd_o.blk_step = 1'b1;
        if (sts_i.blk_done) state_d = SSeg;
      end
      SSeg: begin
        cmd_o.seg_step = 1'b1;
        if (sts_i.seg_done) state_d = SApply;
      end
      SApply: begin
        cmd_o.apply = 1'b1;
        state_d     = sts_i.need_shift ? SShift : SDone;
      end
      SShift: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) state_d = SDone;
      end
      SDone: begin
        cmd_o.finish = 1'b1;
        state_d      = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != SIdle);

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !busy) else $error("load while busy");
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !busy) else $error("finish not followed by idle");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");
endmodule
`default_nettype wire

@@ rtl/core/vpa_dp.sv @@
`default_nettype none
module vpa_dp #(
  parameter int unsigned MaxBlocks = vpa_pkg::MaxBlocksDefault,
  parameter int unsigned AddrBits  = vpa_pkg::AddrBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire vpa_pkg::vpa_cmd_t cmd_i,
  output vpa_pkg::vpa_sts_t      sts_o,
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_idx_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire logic [0:0]        req_type_i,
  input  wire logic [15:0]       alloc_size_i,
  input  wire logic [15:0]       free_id_i,
  output logic                   done_o,
  output logic [2:0]             status_o,
  output logic [15:0]            proc_id_o,
  output logic [15:0]            block_start_o,
  output logic [15:0]            block_size_o
);
  localparam int unsigned SegDepth = MaxBlocks + 1;
  localparam int unsigned SegIdxW  = $clog2(SegDepth + 1);
  localparam int unsigned BlkIdxW  = $clog2(MaxBlocks + 1);
  localparam int unsigned BlkW     = $clog2(MaxBlocks);
  localparam int unsigned SegW     = $clog2(SegDepth);
  localparam int unsigned IdW      = vpa_pkg::IdBits;

  // segment table and block table
  logic [AddrBits-1:0] seg_start_q [SegDepth];
  logic [AddrBits-1:0] seg_len_q   [SegDepth];
  logic [SegIdxW-1:0]  seg_count_q;
  logic [IdW-1:0]      blk_id_q    [MaxBlocks];
  logic [AddrBits-1:0] blk_start_q [MaxBlocks];
  logic [AddrBits-1:0] blk_len_q   [MaxBlocks];
  logic [MaxBlocks-1:0] blk_valid_q;
  logic [IdW-1:0]      last_id_q;
  logic [15:0]         mem_size_q;
  logic [1:0]          fit_q;

  // request and scan registers
  logic [0:0]          rtype_q;
  logic [15:0]         rsize_q;
  logic [15:0]         rid_q;
  logic [BlkIdxW-1:0]  bi_q;        // block scan pointer
  logic [BlkIdxW-1:0]  slot_q;      // found slot, MaxBlocks if none
  logic [SegIdxW-1:0]  si_q;        // segment scan pointer
  logic [SegIdxW-1:0]  pick_q;      // chosen segment / insert point
  logic [AddrBits-1:0] pick_len_q;
  logic                pick_ok_q;
  logic                stop_q;      // block hit, first fit or insert point found
  logic [SegIdxW-1:0]  sh_q;        // shift pointer
  logic                sh_up_q;     // 1: open a gap, 0: close
  logic [SegIdxW-1:0]  sh_end_q;
  logic [2:0]          st_q;
  logic [IdW-1:0]      oid_q;
  logic [AddrBits-1:0] ostart_q;
  logic [AddrBits-1:0] olen_q;
  logic                done_q;

  logic [BlkW-1:0] bi_w;
  logic [SegW-1:0] si_w, pk_w, pkm_w, sh_w;
  logic [SegW-1:0] shm_w;
  logic [SegW-1:0] shp_w;
  assign bi_w  = bi_q[BlkW-1:0];
  assign si_w  = si_q[SegW-1:0];
  assign pk_w  = pick_q[SegW-1:0];
  assign pkm_w = pk_w - SegW'(1);
  assign sh_w  = sh_q[SegW-1:0];
  assign shm_w = sh_w - SegW'(1);
  assign shp_w = sh_w + SegW'(1);

  logic [AddrBits-1:0] size_a;
  assign size_a = AddrBits'(rsize_q);

  logic bad_size, full, fits, blk_hit;
  assign bad_size = (rsize_q == '0) || (rsize_q > mem_size_q);
  assign full     = (slot_q == BlkIdxW'(MaxBlocks)) || (last_id_q >= IdW'(vpa_pkg::IdLimit));
  assign fits     = seg_len_q[si_w] >= size_a;
  assign blk_hit  = (rtype_q == vpa_pkg::ReqAlloc) ? !blk_valid_q[bi_w]
                  : (blk_valid_q[bi_w] && blk_id_q[bi_w] == rid_q);

  // free path: block being returned
  logic [AddrBits-1:0] f_start, f_len;
  logic [BlkW-1:0]     sl_w;
  assign sl_w    = slot_q[BlkW-1:0];
  assign f_start = blk_start_q[sl_w];
  assign f_len   = blk_len_q[sl_w];

  logic join_prev, join_next, free_ok, alloc_go;
  assign free_ok   = (rtype_q == vpa_pkg::ReqFree) && (slot_q != BlkIdxW'(MaxBlocks));
  assign join_prev = (pick_q != '0) &&
                     (seg_start_q[pkm_w] + seg_len_q[pkm_w] == f_start);
  assign join_next = (pick_q < seg_count_q) && (f_start + f_len == seg_start_q[pk_w]);
  assign alloc_go  = (rtype_q == vpa_pkg::ReqAlloc) && !bad_size && !full && pick_ok_q;

  logic need_shift;
  always_comb begin
    need_shift = 1'b0;
    if (alloc_go) begin
      need_shift = (pick_len_q == size_a);
    end else if (free_ok) begin
      need_shift = (join_prev && join_next) ||
                   (!join_prev && !join_next && seg_count_q < SegIdxW'(SegDepth));
    end
  end

  assign sts_o.blk_done   = stop_q || (bi_q == BlkIdxW'(MaxBlocks - 1));
  assign sts_o.seg_done   = stop_q || (si_q >= seg_count_q) || (si_q == SegIdxW'(SegDepth - 1));
  assign sts_o.shift_done = sh_up_q ? (sh_q <= sh_end_q + SegIdxW'(1))
                                    : (sh_q + SegIdxW'(1) >= sh_end_q);
  assign sts_o.need_shift = need_shift;

  logic any_alloc;
  assign any_alloc = |blk_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= SegIdxW'(1);
      seg_start_q[0] <= '0;
      seg_len_q[0]   <= AddrBits'(vpa_pkg::ResetMemSize);
      blk_valid_q <= '0;
      last_id_q   <= '0;
      mem_size_q  <= 16'(vpa_pkg::ResetMemSize);
      fit_q       <= vpa_pkg::FitFirst;
      done_q      <= 1'b0;
      stop_q      <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == vpa_pkg::RegMemSize) begin
          if (cfg_data_i != '0 && !any_alloc) begin
            mem_size_q     <= cfg_data_i;
            seg_start_q[0] <= '0;
            seg_len_q[0]   <= AddrBits'(cfg_data_i);
            seg_count_q    <= SegIdxW'(1);
          end
        end else begin
          fit_q <= cfg_data_i[1:0];
        end
      end
      if (cmd_i.load) begin
        rtype_q   <= req_type_i;
        rsize_q   <= alloc_size_i;
        rid_q     <= free_id_i;
        bi_q      <= '0;
        slot_q    <= BlkIdxW'(MaxBlocks);
        si_q      <= '0;
        pick_q    <= '0;
        pick_ok_q <= 1'b0;
        stop_q    <= 1'b0;
      end
      if (cmd_i.blk_step) begin
        if (!stop_q && blk_hit) begin
          slot_q <= bi_q;
          stop_q <= 1'b1;
        end
        bi_q <= bi_q + BlkIdxW'(1);
        if (sts_o.blk_done) begin
          stop_q <= 1'b0;
          // free: scan finds insert point, default past the end
          pick_q <= seg_count_q;
        end
      end
      if (cmd_i.seg_step && !stop_q && si_q < seg_count_q) begin
        si_q <= si_q + SegIdxW'(1);
        if (rtype_q == vpa_pkg::ReqAlloc) begin
          if (fits) begin
            if (fit_q == vpa_pkg::FitFirst) begin
              pick_q <= si_q; pick_len_q <= seg_len_q[si_w]; pick_ok_q <= 1'b1;
              stop_q <= 1'b1;
            end else if (!pick_ok_q ||
                         (fit_q == vpa_pkg::FitBest  && seg_len_q[si_w] < pick_len_q) ||
                         (fit_q == vpa_pkg::FitWorst && seg_len_q[si_w] > pick_len_q)) begin
              pick_q <= si_q; pick_len_q <= seg_len_q[si_w];
              pick_ok_q <= (fit_q == vpa_pkg::FitBest) || (fit_q == vpa_pkg::FitWorst);
            end
          end
        end else if (seg_start_q[si_w] >= f_start) begin
          pick_q <= si_q;
          stop_q <= 1'b1;
        end
      end
      if (cmd_i.apply) begin
        st_q <= vpa_pkg::StOk; oid_q <= '0; ostart_q <= '0; olen_q <= '0;
        if (rtype_q == vpa_pkg::ReqAlloc) begin
          if (bad_size) st_q <= vpa_pkg::StBadSize;
          else if (full) st_q <= vpa_pkg::StFull;
          else if (!pick_ok_q) st_q <= vpa_pkg::StNoSeg;
          else begin
            last_id_q <= last_id_q + IdW'(1);
            oid_q     <= last_id_q + IdW'(1);
            ostart_q  <= seg_start_q[pk_w];
            olen_q    <= size_a;
            blk_id_q[sl_w]    <= last_id_q + IdW'(1);
            blk_start_q[sl_w] <= seg_start_q[pk_w];
            blk_len_q[sl_w]   <= size_a;
            blk_valid_q[sl_w] <= 1'b1;
            seg_start_q[pk_w] <= seg_start_q[pk_w] + size_a;
            seg_len_q[pk_w]   <= seg_len_q[pk_w] - size_a;
            sh_q <= pick_q; sh_up_q <= 1'b0; sh_end_q <= seg_count_q;
            if (need_shift) seg_count_q <= seg_count_q - SegIdxW'(1);
          end
        end else if (!free_ok) begin
          st_q <= vpa_pkg::StIdUnk;
        end else begin
          oid_q <= blk_id_q[sl_w]; ostart_q <= f_start; olen_q <= f_len;
          blk_valid_q[sl_w] <= 1'b0;
          if (join_prev && join_next) begin
            seg_len_q[pkm_w] <= seg_len_q[pkm_w] + f_len + seg_len_q[pk_w];
            sh_q <= pick_q; sh_up_q <= 1'b0; sh_end_q <= seg_count_q;
            seg_count_q <= seg_count_q - SegIdxW'(1);
          end else if (join_prev) begin
            seg_len_q[pkm_w] <= seg_len_q[pkm_w] + f_len;
          end else if (join_next) begin
            seg_start_q[pk_w] <= f_start;
            seg_len_q[pk_w]   <= seg_len_q[pk_w] + f_len;
          end else if (seg_count_q < SegIdxW'(SegDepth)) begin
            sh_q <= seg_count_q; sh_up_q <= 1'b1; sh_end_q <= pick_q;
            seg_count_q <= seg_count_q + SegIdxW'(1);
          end
        end
      end
      if (cmd_i.shift) begin
        if (sh_up_q) begin
          // move one entry up; last step places the freed segment
          if (sh_q > sh_end_q) begin
            seg_start_q[sh_w] <= seg_start_q[shm_w];
            seg_len_q[sh_w]   <= seg_len_q[shm_w];
            sh_q <= sh_q - SegIdxW'(1);
          end else begin
            seg_start_q[sh_w] <= ostart_q;
            seg_len_q[sh_w]   <= olen_q;
          end
          if (sh_q == sh_end_q + SegIdxW'(1)) begin
            seg_start_q[shm_w] <= ostart_q;
            seg_len_q[shm_w]   <= olen_q;
          end
        end else if (sh_q + SegIdxW'(1) < sh_end_q) begin
          seg_start_q[sh_w] <= seg_start_q[shp_w];
          seg_len_q[sh_w]   <= seg_len_q[shp_w];
          sh_q <= sh_q + SegIdxW'(1);
        end
      end
      if (cmd_i.finish) done_q <= 1'b1;
    end
  end

  assign done_o        = done_q;
  assign status_o      = done_q ? st_q : '0;
  assign proc_id_o     = done_q ? 16'(oid_q) : '0;
  assign block_start_o = done_q ? 16'(ostart_q) : '0;
  assign block_size_o  = done_q ? 16'(olen_q) : '0;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_count_q <= SegIdxW'(SegDepth)) else $error("segment count overflow");
  a_ok_has_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && st_q == vpa_pkg::StOk) |-> oid_q != '0) else $error("ok with id zero");
  a_id_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_id_q >= $past(last_id_q) || $past(!rst_ni)) else $error("id went back");
endmodule
`default_nettype wire

@@ rtl/core/variable_partition_allocator.sv @@
`default_nettype none
// variable partition allocator
// command channel: start with req_type_i, alloc_size_i, free_id_i is taken
// at a clock edge with start high and busy low. busy stays high until
// the result is shown; the next item can be taken in the result cycle.
// result channel: done_o strobes for one cycle with status_o, proc_id_o,
// block_start_o and block_size_o; the receiver cannot stall, so the result
// must be taken in that cycle. outputs read zero when done_o is low.
// config: cfg_we_i, cfg_idx_i (0 memory size, 1 fit policy), cfg_data_i;
// write only while busy is low. a memory size write while blocks are
// allocated is dropped.
// sequence: one item runs a block table scan (stops in the cycle after
// the first hit), a segment scan, a commit step, an optional
// one-entry-per-cycle table shift and a finish step; the result is
// registered from the finish step, one item at a time.
// reset: one free segment of 1024 words, first fit, no blocks, ids from 1.
module variable_partition_allocator #(
  parameter int unsigned MaxBlocks = vpa_pkg::MaxBlocksDefault,
  parameter int unsigned AddrBits  = vpa_pkg::AddrBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic [0:0]  req_type_i,
  input  wire logic [15:0] alloc_size_i,
  input  wire logic [15:0] free_id_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [15:0]      proc_id_o,
  output logic [15:0]      block_start_o,
  output logic [15:0]      block_size_o
);
  vpa_pkg::vpa_cmd_t cmd;
  vpa_pkg::vpa_sts_t sts;

  vpa_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_o (cmd),
    .sts_i (sts)
  );

  vpa_dp #(
    .MaxBlocks(MaxBlocks),
    .AddrBits (AddrBits)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_type_i   (req_type_i),
    .alloc_size_i (alloc_size_i),
    .free_id_i    (free_id_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .proc_id_o    (proc_id_o),
    .block_start_o(block_start_o),
    .block_size_o (block_size_o)
  );
endmodule
`default_nettype wire

@@ dv/tb_variable_partition_allocator.sv @@
`timescale 1ns / 100ps
module tb_variable_partition_allocator;

  localparam int unsigned NBLK      = vpa_pkg::MaxBlocksDefault;
  localparam int unsigned NSEG      = NBLK + 1;
  localparam int unsigned SETTLE    = 3 * NBLK + 12;
  localparam int unsigned WDOG_MAX  = 4000;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] id;
    logic [15:0] start;
    logic [15:0] size;
  } alloc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = vpa_pkg::RegMemSize;
  logic [15:0] cfg_data_i = '0;
  logic [0:0]  req_type_i = vpa_pkg::ReqAlloc;
  logic [15:0] alloc_size_i = '0;
  logic [15:0] free_id_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [15:0] proc_id_o;
  logic [15:0] block_start_o;
  logic [15:0] block_size_o;

  variable_partition_allocator DUT (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_type_i, .alloc_size_i, .free_id_i, .done_o, .status_o, .proc_id_o,
    .block_start_o, .block_size_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // allocator mirror
  int unsigned mem_words;
  logic [1:0]  policy;
  int unsigned free_start [NSEG];
  int unsigned free_len [NSEG];
  int unsigned free_cnt;
  int unsigned used_id [NBLK];
  int unsigned used_start [NBLK];
  int unsigned used_len [NBLK];
  bit          used_vld [NBLK];
  int unsigned next_id;

  alloc_result_t pending_q[$];
  int unsigned   errors = 0;
  int unsigned   idle_pct = 0;
  int unsigned   wdog = 0;

  function automatic void reset_free_table();
    for (int i = 0; i < NSEG; i++) begin
      free_start[i] = 0;
      free_len[i] = 0;
    end
    free_len[0] = mem_words & 16'hFFFF;
    free_cnt = 1;
  endfunction

  function automatic bit blocks_in_use();
    foreach (used_vld[i]) if (used_vld[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int unsigned choose_segment(int unsigned sz);
    int unsigned pick;
    pick = NSEG;
    for (int unsigned i = 0; i < free_cnt && i < NSEG; i++) begin
      if (free_len[i] < sz) continue;
      if (policy == vpa_pkg::FitFirst) return i;
      if (pick == NSEG) pick = i;
      else if (policy == vpa_pkg::FitBest && free_len[i] < free_len[pick]) pick = i;
      else if (policy == vpa_pkg::FitWorst && free_len[i] > free_len[pick]) pick = i;
    end
    if (policy > vpa_pkg::FitFirst) return NSEG;
    return pick;
  endfunction

  function automatic void drop_segment(int unsigned k);
    for (int unsigned i = k; i + 1 < free_cnt && i + 1 < NSEG; i++) begin
      free_start[i] = free_start[i+1];
      free_len[i] = free_len[i+1];
    end
    if (free_cnt > 0) free_cnt--;
  endfunction

  function automatic void return_segment(int unsigned st, int unsigned ln);
    int unsigned p;
    bit jp, jn;
    p = 0;
    while (p < free_cnt && p < NSEG && free_start[p] < st) p++;
    jp = p > 0 && free_start[p-1] + free_len[p-1] == st;
    jn = p < free_cnt && p < NSEG && st + ln == free_start[p];
    if (jp && jn) begin
      free_len[p-1] = (free_len[p-1] + ln + free_len[p]) & 16'hFFFF;
      drop_segment(p);
    end else if (jp) begin
      free_len[p-1] = (free_len[p-1] + ln) & 16'hFFFF;
    end else if (jn) begin
      free_start[p] = st;
      free_len[p] = (free_len[p] + ln) & 16'hFFFF;
    end else if (free_cnt < NSEG) begin
      for (int unsigned i = free_cnt; i > p; i--) begin
        free_start[i] = free_start[i-1];
        free_len[i] = free_len[i-1];
      end
      free_start[p] = st;
      free_len[p] = ln;
      free_cnt++;
    end
  endfunction

  function automatic alloc_result_t serve_request(logic [0:0] kind, logic [15:0] sz,
                                                  logic [15:0] fid);
    alloc_result_t r;
    int unsigned slot, k;
    r = '0;
    slot = NBLK;
    if (kind == vpa_pkg::ReqAlloc) begin
      for (int unsigned i = 0; i < NBLK; i++) if (!used_vld[i]) begin
        slot = i;
        break;
      end
      if (sz == 0 || sz > mem_words) begin
        r.status = vpa_pkg::StBadSize;
      end else if (slot == NBLK || next_id >= vpa_pkg::IdLimit) begin
        r.status = vpa_pkg::StFull;
      end else begin
        k = choose_segment(32'(sz));
        if (k >= NSEG) begin
          r.status = vpa_pkg::StNoSeg;
        end else begin
          next_id++;
          r.status = vpa_pkg::StOk;
          r.id = 16'(next_id);
          r.start = 16'(free_start[k]);
          r.size = sz;
          used_id[slot] = next_id;
          used_start[slot] = free_start[k];
          used_len[slot] = 32'(sz);
          used_vld[slot] = 1'b1;
          free_start[k] = (free_start[k] + 32'(sz)) & 16'hFFFF;
          free_len[k] -= 32'(sz);
          if (free_len[k] == 0) drop_segment(k);
        end
      end
    end else begin
      for (int unsigned i = 0; i < NBLK; i++) if (used_vld[i] && used_id[i] == fid) begin
        slot = i;
        break;
      end
      if (slot == NBLK) begin
        r.status = vpa_pkg::StIdUnk;
      end else begin
        r.status = vpa_pkg::StOk;
        r.id = 16'(used_id[slot]);
        r.start = 16'(used_start[slot]);
        r.size = 16'(used_len[slot]);
        used_vld[slot] = 1'b0;
        return_segment(used_start[slot], used_len[slot]);
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] random_live_id();
    int unsigned live[$];
    foreach (used_vld[i]) if (used_vld[i]) live.push_back(used_id[i]);
    if (live.size() == 0) return 16'd0;
    return 16'(live[$urandom_range(live.size() - 1)]);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    alloc_result_t e;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $error("result with none expected: status %0d id %0d", status_o, proc_id_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          errors++;
        end
        if (proc_id_o !== e.id) begin
          $error("proc_id: expected %0d, got %0d", e.id, proc_id_o);
          errors++;
        end
        if (block_start_o !== e.start) begin
          $error("block_start: expected %0d, got %0d", e.start, block_start_o);
          errors++;
        end
        if (block_size_o !== e.size) begin
          $error("block_size: expected %0d, got %0d", e.size, block_size_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("tb_variable_partition_allocator: done, errors");
      $finish;
    end
  end

  task automatic send_item(logic [0:0] kind, logic [15:0] sz, logic [15:0] fid);
    @(posedge clk_i);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    start <= 1'b1;
    req_type_i <= kind;
    alloc_size_i <= sz;
    free_id_i <= fid;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(serve_request(kind, sz, fid));
    start <= 1'b0;
  endtask

  task automatic alloc_item(logic [15:0] sz);
    send_item(vpa_pkg::ReqAlloc, sz, 16'($urandom()));
  endtask

  task automatic free_item(logic [15:0] fid);
    send_item(vpa_pkg::ReqFree, 16'($urandom()), fid);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    int unsigned v;
    wait (pending_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == vpa_pkg::RegMemSize) begin
      v = 32'(val);
      if (v != 0 && !blocks_in_use()) begin
        mem_words = v;
        reset_free_table();
      end
    end else begin
      policy = val[1:0];
    end
  endtask

  task automatic release_all();
    while (blocks_in_use()) free_item(random_live_id());
  endtask

  task automatic test_directed();
    alloc_item(16'd0);
    alloc_item(16'd1025);
    alloc_item(16'hFFFF);
    free_item(16'd0);
    free_item(16'hFFFF);
    alloc_item(16'd1024);
    alloc_item(16'd1);         // empty free table
    free_item(16'd1);
    alloc_item(16'd100);
    alloc_item(16'd200);
    alloc_item(16'd300);
    free_item(16'd3);          // isolated hole
    free_item(16'd2);          // joins the hole above
    free_item(16'd3);          // already gone
    free_item(16'd4);          // merges on both sides
    release_all();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < NBLK; i++) alloc_item(16'(8 + i));
    alloc_item(16'd1);
    write_reg(vpa_pkg::RegMemSize, 16'd512);  // dropped, blocks in use
    for (int i = 0; i < NBLK; i += 2) free_item(random_live_id());
    alloc_item(16'd3);
    release_all();
  endtask

  task automatic test_sizes();
    write_reg(vpa_pkg::RegMemSize, 16'd0);    // dropped
    write_reg(vpa_pkg::RegMemSize, 16'd1);
    alloc_item(16'd2);
    alloc_item(16'd1);
    alloc_item(16'd1);
    release_all();
    write_reg(vpa_pkg::RegMemSize, 16'hFFFF);
    alloc_item(16'hFFFF);
    alloc_item(16'h8000);
    release_all();
    write_reg(vpa_pkg::RegFit, 16'd3);         // unused policy
    alloc_item(16'd5);
    alloc_item(16'd0);
    free_item(16'd1);
  endtask

  task automatic test_random_phase(int unsigned pct, logic [15:0] mem, logic [1:0] fit,
                                   int unsigned n);
    int unsigned r;
    logic [15:0] sz;
    release_all();
    write_reg(vpa_pkg::RegMemSize, mem);
    write_reg(vpa_pkg::RegFit, 16'(fit));
    idle_pct = pct;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        sz = 16'($urandom_range(1, (mem / 6) + 1));
        alloc_item(sz);
      end else if (r < 62) begin
        alloc_item(16'($urandom()));
      end else if (r < 95) begin
        free_item(random_live_id());
      end else begin
        free_item(16'($urandom()));
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    mem_words = vpa_pkg::ResetMemSize;
    policy = vpa_pkg::FitFirst;
    reset_free_table();
    foreach (used_vld[i]) begin
      used_vld[i] = 1'b0;
      used_id[i] = 0;
      used_start[i] = 0;
      used_len[i] = 0;
    end
    next_id = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_table_full();
    test_sizes();
    test_random_phase(0, 16'd1024, vpa_pkg::FitBest, 250);
    test_random_phase(63, 16'd37, vpa_pkg::FitWorst, 250);
    test_random_phase(7, 16'hFFFF, vpa_pkg::FitFirst, 250);
    test_random_phase(0, 16'd300, vpa_pkg::FitBest, 250);
    wait (pending_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_variable_partition_allocator: done, clean");
    end else begin
      $display("tb_variable_partition_allocator: done, errors");
    end
    $finish;
  end

endmodule
